[hdl/wlsc_pkg.sv]
`timescale 1ns / 1ps

package wlsc_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_SKIP    = 3'd3,
    PH_NAMELEN = 3'd4,
    PH_NAME    = 3'd5,
    PH_LANG    = 3'd6,
    PH_DRAIN   = 3'd7
  } phase_t;

  // Outcome of feeding one byte to a LEB128 decoder.
  typedef enum logic [1:0] {
    LEB_MORE = 2'd0,
    LEB_DONE = 2'd1,
    LEB_FAIL = 2'd2
  } leb_code_t;

  typedef struct packed {
    logic [31:0] accum;
    logic [2:0]  count;
    leb_code_t   code;
  } leb_step_t;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_WASM    = 3'd1;
  localparam logic [2:0] ST_BAD_SECTION = 3'd2;
  localparam logic [2:0] ST_BAD_CUSTOM  = 3'd3;
  localparam logic [2:0] ST_DUPLICATE   = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_NONE_DECL   = 3'd6;

  // Language codes.
  localparam logic [1:0] LANG_NONE = 2'd0;
  localparam logic [1:0] LANG_RUST = 2'd1;
  localparam logic [1:0] LANG_AS   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NAME_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_NAME_BYTES_0 = 3'd1;
  localparam logic [2:0] CFG_NAME_BYTES_1 = 3'd2;
  localparam logic [2:0] CFG_NAME_BYTES_2 = 3'd3;
  localparam logic [2:0] CFG_NAME_BYTES_3 = 3'd4;

  // Byte constants.
  localparam logic [7:0] MAGIC [8] = '{8'h00, 8'h61, 8'h73, 8'h6d,
                                       8'h01, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] RUST_WORD [4] = '{8'h72, 8'h75, 8'h73, 8'h74};
  localparam logic [7:0] AS_WORD [14] = '{8'h61, 8'h73, 8'h73, 8'h65, 8'h6d, 8'h62, 8'h6c,
                                          8'h79, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
  localparam int RUST_LEN = 4;
  localparam int AS_LEN   = 14;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] language;
  } result_t;

endpackage

[hdl/wlsc_if.sv]
`timescale 1ns / 1ps

// Input channel: one module byte per transfer.
interface wlsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_module;

  modport source(output valid, data_byte, end_of_module, input ready);
  modport sink(input valid, data_byte, end_of_module, output ready);
endinterface

// Result channel: one status and language per module.
interface wlsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] language;

  modport source(output valid, status, language, input ready);
  modport sink(input valid, status, language, output ready);
endinterface

// Configuration write channel.
interface wlsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/wasm_language_section_checker.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                          Transfer when
// in_chan   sink       data_byte[7:0], end_of_module    in_chan.valid && in_chan.ready
// out_chan  source     status[2:0], language[1:0]       out_chan.valid && out_chan.ready
// cfg_chan  sink       index[2:0], data[63:0]           cfg_chan.valid (ready is always high)
//
// Every input byte is handled as it is taken, so a byte can be taken on every clock.
// The only thing that holds the input back is the result register: while it is
// full and the consumer does not take it, in_chan.ready is low.
// A result is produced only on the byte flagged end_of_module and appears on
// out_chan the cycle after that transfer.
// Reset (rst_n low at a clock edge) clears the parser, the configuration and
// the result register; the block is ready the first cycle after reset.
module wasm_language_section_checker #(
  parameter int MAX_NAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  wlsc_in_if.sink     in_chan,
  wlsc_out_if.source  out_chan,
  wlsc_cfg_if.sink    cfg_chan
);

  // Configuration registers.
  logic [5:0]   name_length_r;
  logic [255:0] name_bytes_r;

  // Parser state.
  wlsc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  header_count_r, header_count_nxt;
  logic [31:0] leb_accum_r, leb_accum_nxt;
  logic [2:0]  leb_count_r, leb_count_nxt;
  logic        section_custom_r, section_custom_nxt;
  logic [31:0] section_left_r, section_left_nxt;
  logic [31:0] name_left_r, name_left_nxt;
  logic [5:0]  name_pos_r, name_pos_nxt;
  logic        name_match_r, name_match_nxt;
  logic [3:0]  lang_pos_r, lang_pos_nxt;
  logic [1:0]  lang_flags_r, lang_flags_nxt;
  logic [1:0]  found_lang_r, found_lang_nxt;
  logic [2:0]  committed_r, committed_nxt;
  logic [2:0]  pending_r, pending_nxt;

  logic              in_fire;
  logic              can_load;
  logic              res_load;
  wlsc_pkg::result_t res_value;
  wlsc_pkg::leb_step_t leb;
  logic              finish;
  logic [1:0]        sec_lang;
  logic [7:0]        cfg_name_byte;
  logic [7:0]        b;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = can_load;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign res_load       = in_fire && in_chan.end_of_module;
  assign b              = in_chan.data_byte;

  // Configured name byte at the current name position; bytes past the
  // stored 32 read as zero.
  assign cfg_name_byte = name_pos_r[5] ? 8'h00 : name_bytes_r[{name_pos_r[4:0], 3'b000} +: 8];

  // One LEB128 byte: at most five bytes, and the fifth may carry only the
  // four bits that still fit in 32.
  function automatic wlsc_pkg::leb_step_t leb_feed(logic [31:0] acc, logic [2:0] cnt,
                                                   logic [7:0] byte_in);
    wlsc_pkg::leb_step_t r;
    r.accum = acc;
    r.count = cnt;
    r.code  = wlsc_pkg::LEB_MORE;
    if (cnt >= 3'd4) begin
      if (byte_in[7] || (byte_in[6:4] != 3'd0)) begin
        r.code = wlsc_pkg::LEB_FAIL;
      end else begin
        r.accum = acc | {byte_in[3:0], 28'd0};
        r.code  = wlsc_pkg::LEB_DONE;
      end
    end else begin
      case (cnt[1:0])
        2'd0: begin
          r.accum = acc | {25'd0, byte_in[6:0]};
        end
        2'd1: begin
          r.accum = acc | {18'd0, byte_in[6:0], 7'd0};
        end
        2'd2: begin
          r.accum = acc | {11'd0, byte_in[6:0], 14'd0};
        end
        default: begin
          r.accum = acc | {4'd0, byte_in[6:0], 21'd0};
        end
      endcase
      r.count = cnt + 3'd1;
      r.code  = byte_in[7] ? wlsc_pkg::LEB_MORE : wlsc_pkg::LEB_DONE;
    end
    return r;
  endfunction

  assign leb = leb_feed(leb_accum_r, leb_count_r, b);

  // Next-state logic. The byte is consumed first; a section whose last byte
  // this is then gets closed, and on the final byte the status is formed from
  // the updated state before everything returns to reset values.
  always_comb begin
    phase_nxt          = phase_r;
    header_count_nxt   = header_count_r;
    leb_accum_nxt      = leb_accum_r;
    leb_count_nxt      = leb_count_r;
    section_custom_nxt = section_custom_r;
    section_left_nxt   = section_left_r;
    name_left_nxt      = name_left_r;
    name_pos_nxt       = name_pos_r;
    name_match_nxt     = name_match_r;
    lang_pos_nxt       = lang_pos_r;
    lang_flags_nxt     = lang_flags_r;
    found_lang_nxt     = found_lang_r;
    committed_nxt      = committed_r;
    pending_nxt        = pending_r;
    finish             = 1'b0;
    sec_lang           = wlsc_pkg::LANG_NONE;
    res_value.status   = wlsc_pkg::ST_OK;
    res_value.language = wlsc_pkg::LANG_NONE;

    if (in_fire) begin
      case (phase_r)
        wlsc_pkg::PH_HEADER: begin
          if (b != wlsc_pkg::MAGIC[header_count_r[2:0]]) begin
            committed_nxt = wlsc_pkg::ST_NOT_WASM;
            phase_nxt     = wlsc_pkg::PH_DRAIN;
          end else begin
            header_count_nxt = header_count_r + 4'd1;
            if (header_count_nxt[3]) begin
              phase_nxt = wlsc_pkg::PH_ID;
            end
          end
        end
        wlsc_pkg::PH_ID: begin
          section_custom_nxt = (b == 8'h00);
          leb_accum_nxt      = 32'd0;
          leb_count_nxt      = 3'd0;
          phase_nxt          = wlsc_pkg::PH_SIZE;
        end
        wlsc_pkg::PH_SIZE: begin
          leb_accum_nxt = leb.accum;
          leb_count_nxt = leb.count;
          if (leb.code == wlsc_pkg::LEB_FAIL) begin
            if (committed_r == wlsc_pkg::ST_OK) begin
              committed_nxt = wlsc_pkg::ST_BAD_SECTION;
            end
            phase_nxt = wlsc_pkg::PH_DRAIN;
          end else if (leb.code == wlsc_pkg::LEB_DONE) begin
            section_left_nxt = leb.accum;
            pending_nxt      = wlsc_pkg::ST_OK;
            if (section_custom_r) begin
              leb_accum_nxt = 32'd0;
              leb_count_nxt = 3'd0;
              phase_nxt     = wlsc_pkg::PH_NAMELEN;
            end else begin
              phase_nxt = wlsc_pkg::PH_SKIP;
            end
            finish = (leb.accum == 32'd0);
          end
        end
        wlsc_pkg::PH_DRAIN: begin
        end
        default: begin
          // Section body byte.
          section_left_nxt = section_left_r - 32'd1;
          case (phase_r)
            wlsc_pkg::PH_NAMELEN: begin
              leb_accum_nxt = leb.accum;
              leb_count_nxt = leb.count;
              if (leb.code == wlsc_pkg::LEB_FAIL) begin
                if (pending_nxt == wlsc_pkg::ST_OK) pending_nxt = wlsc_pkg::ST_BAD_CUSTOM;
                phase_nxt = wlsc_pkg::PH_SKIP;
              end else if (leb.code == wlsc_pkg::LEB_DONE) begin
                if (leb.accum > section_left_nxt) begin
                  if (pending_nxt == wlsc_pkg::ST_OK) pending_nxt = wlsc_pkg::ST_BAD_CUSTOM;
                  phase_nxt = wlsc_pkg::PH_SKIP;
                end else begin
                  name_left_nxt  = leb.accum;
                  name_pos_nxt   = 6'd0;
                  name_match_nxt = ({1'b0, name_length_r} <= 7'(MAX_NAME_BYTES)) &&
                                   (leb.accum == {26'd0, name_length_r});
                  if (leb.accum == 32'd0) begin
                    if (name_match_nxt) begin
                      lang_pos_nxt   = 4'd0;
                      lang_flags_nxt = 2'b11;
                      phase_nxt      = wlsc_pkg::PH_LANG;
                    end else begin
                      phase_nxt = wlsc_pkg::PH_SKIP;
                    end
                  end else begin
                    phase_nxt = wlsc_pkg::PH_NAME;
                  end
                end
              end
            end
            wlsc_pkg::PH_NAME: begin
              if (({1'b0, name_pos_r} >= 7'(MAX_NAME_BYTES)) || (b != cfg_name_byte)) begin
                name_match_nxt = 1'b0;
              end
              if (name_pos_r != 6'd63) name_pos_nxt = name_pos_r + 6'd1;
              name_left_nxt = name_left_r - 32'd1;
              if (name_left_nxt == 32'd0) begin
                if (name_match_nxt) begin
                  lang_pos_nxt   = 4'd0;
                  lang_flags_nxt = 2'b11;
                  phase_nxt      = wlsc_pkg::PH_LANG;
                end else begin
                  phase_nxt = wlsc_pkg::PH_SKIP;
                end
              end
            end
            wlsc_pkg::PH_LANG: begin
              if ((lang_pos_r >= 4'(wlsc_pkg::RUST_LEN)) ||
                  (b != wlsc_pkg::RUST_WORD[lang_pos_r[1:0]])) begin
                lang_flags_nxt[0] = 1'b0;
              end
              if ((lang_pos_r >= 4'(wlsc_pkg::AS_LEN)) ||
                  (b != wlsc_pkg::AS_WORD[(lang_pos_r < 4'(wlsc_pkg::AS_LEN)) ?
                                          lang_pos_r : 4'd0])) begin
                lang_flags_nxt[1] = 1'b0;
              end
              if (lang_pos_r != 4'd15) lang_pos_nxt = lang_pos_r + 4'd1;
            end
            default: begin
            end
          endcase
          finish = (section_left_nxt == 32'd0);
        end
      endcase

      // Section close: errors found inside the body are committed only now.
      if (finish) begin
        if ((phase_nxt == wlsc_pkg::PH_NAMELEN) || (phase_nxt == wlsc_pkg::PH_NAME)) begin
          if (pending_nxt == wlsc_pkg::ST_OK) pending_nxt = wlsc_pkg::ST_BAD_CUSTOM;
        end else if (phase_nxt == wlsc_pkg::PH_LANG) begin
          if (found_lang_nxt != wlsc_pkg::LANG_NONE) begin
            if (pending_nxt == wlsc_pkg::ST_OK) pending_nxt = wlsc_pkg::ST_DUPLICATE;
          end else if (lang_flags_nxt[0] && (lang_pos_nxt == 4'(wlsc_pkg::RUST_LEN))) begin
            sec_lang = wlsc_pkg::LANG_RUST;
          end else if (lang_flags_nxt[1] && (lang_pos_nxt == 4'(wlsc_pkg::AS_LEN))) begin
            sec_lang = wlsc_pkg::LANG_AS;
          end else begin
            if (pending_nxt == wlsc_pkg::ST_OK) pending_nxt = wlsc_pkg::ST_UNSUPPORTED;
          end
        end
        if (committed_nxt == wlsc_pkg::ST_OK) begin
          if (pending_nxt != wlsc_pkg::ST_OK) begin
            committed_nxt = pending_nxt;
          end else if (sec_lang != wlsc_pkg::LANG_NONE) begin
            found_lang_nxt = sec_lang;
          end
        end
        pending_nxt        = wlsc_pkg::ST_OK;
        section_custom_nxt = 1'b0;
        phase_nxt          = wlsc_pkg::PH_ID;
      end

      // Final byte: form the status, then return the parser to reset.
      if (in_chan.end_of_module) begin
        if (committed_nxt != wlsc_pkg::ST_OK) begin
          res_value.status = committed_nxt;
        end else if (phase_nxt == wlsc_pkg::PH_HEADER) begin
          res_value.status = wlsc_pkg::ST_NOT_WASM;
        end else if ((phase_nxt != wlsc_pkg::PH_ID) && (phase_nxt != wlsc_pkg::PH_DRAIN)) begin
          res_value.status = wlsc_pkg::ST_BAD_SECTION;
        end else if (found_lang_nxt == wlsc_pkg::LANG_NONE) begin
          res_value.status = wlsc_pkg::ST_NONE_DECL;
        end else begin
          res_value.status   = wlsc_pkg::ST_OK;
          res_value.language = found_lang_nxt;
        end
        phase_nxt          = wlsc_pkg::PH_HEADER;
        header_count_nxt   = 4'd0;
        leb_accum_nxt      = 32'd0;
        leb_count_nxt      = 3'd0;
        section_custom_nxt = 1'b0;
        section_left_nxt   = 32'd0;
        name_left_nxt      = 32'd0;
        name_pos_nxt       = 6'd0;
        name_match_nxt     = 1'b1;
        lang_pos_nxt       = 4'd0;
        lang_flags_nxt     = 2'b11;
        found_lang_nxt     = wlsc_pkg::LANG_NONE;
        committed_nxt      = wlsc_pkg::ST_OK;
        pending_nxt        = wlsc_pkg::ST_OK;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= wlsc_pkg::PH_HEADER;
      header_count_r   <= 4'd0;
      leb_accum_r      <= 32'd0;
      leb_count_r      <= 3'd0;
      section_custom_r <= 1'b0;
      section_left_r   <= 32'd0;
      name_left_r      <= 32'd0;
      name_pos_r       <= 6'd0;
      name_match_r     <= 1'b1;
      lang_pos_r       <= 4'd0;
      lang_flags_r     <= 2'b11;
      found_lang_r     <= wlsc_pkg::LANG_NONE;
      committed_r      <= wlsc_pkg::ST_OK;
      pending_r        <= wlsc_pkg::ST_OK;
    end else begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      leb_accum_r      <= leb_accum_nxt;
      leb_count_r      <= leb_count_nxt;
      section_custom_r <= section_custom_nxt;
      section_left_r   <= section_left_nxt;
      name_left_r      <= name_left_nxt;
      name_pos_r       <= name_pos_nxt;
      name_match_r     <= name_match_nxt;
      lang_pos_r       <= lang_pos_nxt;
      lang_flags_r     <= lang_flags_nxt;
      found_lang_r     <= found_lang_nxt;
      committed_r      <= committed_nxt;
      pending_r        <= pending_nxt;
    end
  end

  // Configuration writes. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_length_r <= 6'd0;
      name_bytes_r  <= 256'd0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        wlsc_pkg::CFG_NAME_LENGTH:  name_length_r          <= cfg_chan.data[5:0];
        wlsc_pkg::CFG_NAME_BYTES_0: name_bytes_r[63:0]     <= cfg_chan.data;
        wlsc_pkg::CFG_NAME_BYTES_1: name_bytes_r[127:64]   <= cfg_chan.data;
        wlsc_pkg::CFG_NAME_BYTES_2: name_bytes_r[191:128]  <= cfg_chan.data;
        wlsc_pkg::CFG_NAME_BYTES_3: name_bytes_r[255:192]  <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  // Result register decouples the consumer from the byte stream.
  wlsc_result_reg u_result_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .res_in   (res_value),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

[hdl/wlsc_result_reg.sv]
`timescale 1ns / 1ps

// Output register for the result channel. A new result may be loaded in the
// same cycle the held one is taken.
module wlsc_result_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wlsc_pkg::result_t res_in,
  output logic              can_load,
  wlsc_out_if.source        out_chan
);

  logic              valid_r;
  logic              valid_nxt;
  wlsc_pkg::result_t res_r;

  assign can_load  = !valid_r || out_chan.ready;
  assign valid_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_chan.valid    = valid_r;
  assign out_chan.status   = res_r.status;
  assign out_chan.language = res_r.language;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // The block is built with its default name capacity.
  localparam int NAME_MAX = 32;
  localparam int BYTE_TARGET = 2000;
  // Order in which a full name setting is loaded through the configuration channel.
  localparam logic [2:0] REG_ORDER [5] = '{wlsc_pkg::CFG_NAME_LENGTH,
                                           wlsc_pkg::CFG_NAME_BYTES_0,
                                           wlsc_pkg::CFG_NAME_BYTES_1,
                                           wlsc_pkg::CFG_NAME_BYTES_2,
                                           wlsc_pkg::CFG_NAME_BYTES_3};

  typedef bit [7:0] octet_t;

  // The scoreboard mirrors the parser byte by byte. Every accepted input byte advances
  // the mirror; a byte flagged as the end of the module yields one expected verdict.
  class lang_scoreboard;
    logic [5:0]  cfg_len;
    logic [63:0] cfg_name [4];

    wlsc_pkg::phase_t phase;
    logic [3:0]  hdr_cnt;
    logic [31:0] leb_val;
    logic [2:0]  leb_n;
    bit          in_custom;
    logic [31:0] body_left;
    logic [31:0] name_left;
    logic [5:0]  name_pos;
    bit          name_ok;
    logic [3:0]  word_pos;
    logic [1:0]  word_ok;
    logic [1:0]  found;
    logic [2:0]  committed;
    logic [2:0]  pending;

    wlsc_pkg::result_t verdict_q [$];
    int      fails;

    function new();
      cfg_len = '0;
      foreach (cfg_name[i]) cfg_name[i] = '0;
      fails = 0;
      rewind();
    endfunction

    function void rewind();
      phase = wlsc_pkg::PH_HEADER;
      hdr_cnt = '0;
      leb_val = '0;
      leb_n = '0;
      in_custom = 1'b0;
      body_left = '0;
      name_left = '0;
      name_pos = '0;
      name_ok = 1'b1;
      word_pos = '0;
      word_ok = 2'b11;
      found = wlsc_pkg::LANG_NONE;
      committed = '0;
      pending = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        wlsc_pkg::CFG_NAME_LENGTH:  cfg_len = val[5:0];
        wlsc_pkg::CFG_NAME_BYTES_0: cfg_name[0] = val;
        wlsc_pkg::CFG_NAME_BYTES_1: cfg_name[1] = val;
        wlsc_pkg::CFG_NAME_BYTES_2: cfg_name[2] = val;
        wlsc_pkg::CFG_NAME_BYTES_3: cfg_name[3] = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] name_byte(int pos);
      if (pos >= NAME_MAX) return 8'h00;
      return cfg_name[pos / 8][8 * (pos % 8) +: 8];
    endfunction

    function wlsc_pkg::leb_code_t leb_step(logic [7:0] b);
      if (leb_n >= 3'd4) begin
        if (b[7] || b[6:4] != 3'b000) return wlsc_pkg::LEB_FAIL;
        leb_val |= {b[3:0], 28'd0};
        return wlsc_pkg::LEB_DONE;
      end
      leb_val |= 32'(b[6:0]) << (7 * leb_n);
      leb_n++;
      return b[7] ? wlsc_pkg::LEB_MORE : wlsc_pkg::LEB_DONE;
    endfunction

    function void flag(logic [2:0] code);
      if (pending == '0) pending = code;
    endfunction

    function void name_end();
      if (name_ok) begin
        word_pos = '0;
        word_ok = 2'b11;
        phase = wlsc_pkg::PH_LANG;
      end else begin
        phase = wlsc_pkg::PH_SKIP;
      end
    endfunction

    function void close_section();
      logic [1:0] lang;
      lang = wlsc_pkg::LANG_NONE;
      if (phase == wlsc_pkg::PH_NAMELEN || phase == wlsc_pkg::PH_NAME) begin
        flag(wlsc_pkg::ST_BAD_CUSTOM);
      end else if (phase == wlsc_pkg::PH_LANG) begin
        if (found != wlsc_pkg::LANG_NONE) flag(wlsc_pkg::ST_DUPLICATE);
        else if (word_ok[0] && word_pos == wlsc_pkg::RUST_LEN) lang = wlsc_pkg::LANG_RUST;
        else if (word_ok[1] && word_pos == wlsc_pkg::AS_LEN) lang = wlsc_pkg::LANG_AS;
        else flag(wlsc_pkg::ST_UNSUPPORTED);
      end
      if (committed == '0) begin
        if (pending != '0) committed = pending;
        else if (lang != wlsc_pkg::LANG_NONE) found = lang;
      end
      pending = '0;
      in_custom = 1'b0;
      phase = wlsc_pkg::PH_ID;
    endfunction

    function void body_byte(logic [7:0] b);
      wlsc_pkg::leb_code_t r;
      body_left--;
      case (phase)
        wlsc_pkg::PH_NAMELEN: begin
          r = leb_step(b);
          if (r == wlsc_pkg::LEB_FAIL) begin
            flag(wlsc_pkg::ST_BAD_CUSTOM);
            phase = wlsc_pkg::PH_SKIP;
          end else if (r == wlsc_pkg::LEB_DONE) begin
            if (leb_val > body_left) begin
              flag(wlsc_pkg::ST_BAD_CUSTOM);
              phase = wlsc_pkg::PH_SKIP;
            end else begin
              name_left = leb_val;
              name_pos = '0;
              name_ok = (cfg_len <= NAME_MAX) && (leb_val == {26'd0, cfg_len});
              if (name_left == '0) name_end();
              else phase = wlsc_pkg::PH_NAME;
            end
          end
        end
        wlsc_pkg::PH_NAME: begin
          if (name_pos >= NAME_MAX || b != name_byte(name_pos)) name_ok = 1'b0;
          if (name_pos < 6'd63) name_pos++;
          name_left--;
          if (name_left == '0) name_end();
        end
        wlsc_pkg::PH_LANG: begin
          if (word_pos >= wlsc_pkg::RUST_LEN) word_ok[0] = 1'b0;
          else if (b != wlsc_pkg::RUST_WORD[word_pos]) word_ok[0] = 1'b0;
          if (word_pos >= wlsc_pkg::AS_LEN) word_ok[1] = 1'b0;
          else if (b != wlsc_pkg::AS_WORD[word_pos]) word_ok[1] = 1'b0;
          if (word_pos < 4'd15) word_pos++;
        end
        default: ;
      endcase
      if (body_left == '0) close_section();
    endfunction

    function void note_byte(logic [7:0] b, logic eom);
      wlsc_pkg::leb_code_t r;
      wlsc_pkg::result_t   v;
      case (phase)
        wlsc_pkg::PH_HEADER: begin
          if (b != wlsc_pkg::MAGIC[hdr_cnt[2:0]]) begin
            committed = wlsc_pkg::ST_NOT_WASM;
            phase = wlsc_pkg::PH_DRAIN;
          end else begin
            hdr_cnt++;
            if (hdr_cnt >= 4'd8) phase = wlsc_pkg::PH_ID;
          end
        end
        wlsc_pkg::PH_ID: begin
          in_custom = (b == 8'h00);
          leb_val = '0;
          leb_n = '0;
          phase = wlsc_pkg::PH_SIZE;
        end
        wlsc_pkg::PH_SIZE: begin
          r = leb_step(b);
          if (r == wlsc_pkg::LEB_FAIL) begin
            if (committed == '0) committed = wlsc_pkg::ST_BAD_SECTION;
            phase = wlsc_pkg::PH_DRAIN;
          end else if (r == wlsc_pkg::LEB_DONE) begin
            body_left = leb_val;
            pending = '0;
            if (in_custom) begin
              leb_val = '0;
              leb_n = '0;
              phase = wlsc_pkg::PH_NAMELEN;
            end else begin
              phase = wlsc_pkg::PH_SKIP;
            end
            if (body_left == '0) close_section();
          end
        end
        wlsc_pkg::PH_DRAIN: ;
        default: body_byte(b);
      endcase
      if (eom) begin
        v.language = wlsc_pkg::LANG_NONE;
        if (committed != '0) v.status = committed;
        else if (phase == wlsc_pkg::PH_HEADER) v.status = wlsc_pkg::ST_NOT_WASM;
        else if (phase != wlsc_pkg::PH_ID && phase != wlsc_pkg::PH_DRAIN)
          v.status = wlsc_pkg::ST_BAD_SECTION;
        else if (found == wlsc_pkg::LANG_NONE) v.status = wlsc_pkg::ST_NONE_DECL;
        else begin
          v.status = wlsc_pkg::ST_OK;
          v.language = found;
        end
        verdict_q.push_back(v);
        rewind();
      end
    endfunction

    function void check_verdict(logic [2:0] st, logic [1:0] lang);
      wlsc_pkg::result_t v;
      if (verdict_q.size() == 0) begin
        $error("unexpected result transfer: status %0d language %0d", st, lang);
        fails++;
        return;
      end
      v = verdict_q.pop_front();
      if (st !== v.status) begin
        $error("status mismatch: expected %0d, actual %0d", v.status, st);
        fails++;
      end
      if (lang !== v.language) begin
        $error("language mismatch: expected %0d, actual %0d", v.language, lang);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wlsc_in_if  in_chan();
  wlsc_out_if out_chan();
  wlsc_cfg_if cfg_chan();

  wasm_language_section_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  lang_scoreboard sb = new();

  // The module image that is being assembled, and the bookkeeping of the stream.
  octet_t image [$];
  int     bytes_sent;
  int     modules_sent;
  // When set, neither the byte source nor the result sink inserts idle cycles.
  bit     quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Every transfer is observed at the clock edge where it happens. Input bytes are fed
  // to the scoreboard before results are checked, so a verdict can never be compared
  // ahead of the byte that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) sb.write_reg(cfg_chan.index, cfg_chan.data);
      if (in_chan.valid && in_chan.ready) sb.note_byte(in_chan.data_byte, in_chan.end_of_module);
      if (out_chan.valid && out_chan.ready) sb.check_verdict(out_chan.status, out_chan.language);
    end
  end

  // The result sink draws a stall before each result and then holds ready high until
  // the transfer happens. Ready is given a known value in the very first time step.
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!(out_chan.valid && out_chan.ready)) @(posedge clk);
    end
  end

  // Offers one byte after a random gap and returns at the edge of its transfer.
  // Valid is left high so that back-to-back bytes need no extra assignment.
  task automatic push_byte(input octet_t b, input bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.end_of_module <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_image();
    for (int k = 0; k < image.size(); k++) push_byte(image[k], k == image.size() - 1);
    bytes_sent += image.size();
    modules_sent++;
  endtask

  // Stops the byte stream and waits until every verdict has come back.
  // The result is registered and shows up in the cycle after the last byte.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Loads a complete name setting as one burst of configuration transfers.
  // The unused upper bits of the length word carry random junk on purpose.
  task automatic write_name_regs(input bit [5:0] len, input bit [63:0] words [4]);
    bit [63:0] junk;
    junk = {$urandom(), $urandom()};
    cfg_chan.valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_chan.index <= REG_ORDER[i];
      cfg_chan.data <= (i == 0) ? {junk[63:6], len} : words[i - 1];
      @(posedge clk);
      while (!cfg_chan.ready) @(posedge clk);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // Picks a new language-section name. Lengths above the capacity can never match,
  // which is checked along with the empty name and the longest legal one.
  task automatic pick_setting();
    bit [5:0]  len;
    bit [63:0] words [4];
    case ($urandom_range(0, 9))
      0:       len = 6'd0;
      1:       len = 6'(NAME_MAX);
      2:       len = 6'd63;
      3:       len = 6'($urandom_range(NAME_MAX + 1, 62));
      default: len = 6'($urandom_range(1, 12));
    endcase
    foreach (words[i]) words[i] = ($urandom_range(0, 7) == 0) ? '1 : {$urandom(), $urandom()};
    write_name_regs(len, words);
  endtask

  // Mostly one-byte LEB128 encodings, sometimes padded out to as many as five bytes.
  function automatic int pad_width();
    if ($urandom_range(0, 9) == 0) return $urandom_range(2, 5);
    return 1;
  endfunction

  function automatic void add_leb(ref octet_t q [$], input bit [31:0] v, input int width);
    int     n;
    octet_t o;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if (width > n) n = width;
    for (int i = 0; i < n; i++) begin
      o = octet_t'((v >> (7 * i)) & 32'h7f);
      if (i < n - 1) o[7] = 1'b1;
      q.push_back(o);
    end
  endfunction

  // Five-byte LEB whose last byte either continues or overflows 32 bits.
  function automatic void add_bad_leb(ref octet_t q [$]);
    octet_t o;
    int     bit_idx;
    repeat (4) q.push_back(octet_t'($urandom_range(0, 127)) | 8'h80);
    o = octet_t'($urandom_range(0, 255));
    if (!o[7] && o[6:4] == 3'b000) begin
      bit_idx = $urandom_range(4, 6);
      o[bit_idx] = 1'b1;
    end
    q.push_back(o);
  endfunction

  // Language text: the two known words, their prefixes, words with a trailing byte,
  // and plain garbage.
  function automatic void add_word(ref octet_t q [$]);
    int v;
    int wlen;
    int cnt;
    bit pick_rust;
    v = $urandom_range(0, 9);
    if (v == 9) begin
      repeat ($urandom_range(0, 5)) q.push_back(octet_t'($urandom_range(0, 255)));
      return;
    end
    pick_rust = (v < 4) || (v >= 7 && $urandom_range(0, 1) == 1);
    wlen = pick_rust ? wlsc_pkg::RUST_LEN : wlsc_pkg::AS_LEN;
    cnt = (v == 7) ? $urandom_range(0, wlen - 1) : wlen;
    for (int k = 0; k < cnt; k++) begin
      if (pick_rust) q.push_back(wlsc_pkg::RUST_WORD[k]);
      else q.push_back(wlsc_pkg::AS_WORD[k]);
    end
    if (v == 8) q.push_back(octet_t'($urandom_range(0, 255)));
  endfunction

  // A custom section. Most carry the configured name so that the language text is
  // actually examined; the rest use a wrong byte, a wrong length or random names.
  function automatic void add_custom();
    octet_t body [$];
    int     mode;
    int     nlen;
    int     sz;
    int     k;
    mode = $urandom_range(0, 9);
    nlen = sb.cfg_len;
    if (mode == 8) nlen = ($urandom_range(0, 1) == 1 && nlen > 0) ? nlen - 1 : nlen + 1;
    if (mode == 9) nlen = $urandom_range(0, 40);
    if ($urandom_range(0, 15) == 0) add_bad_leb(body);
    else add_leb(body, nlen, pad_width());
    for (k = 0; k < nlen; k++) begin
      if (mode == 9) body.push_back(octet_t'($urandom_range(0, 255)));
      else body.push_back(sb.name_byte(k));
    end
    if (mode == 7 && nlen > 0) begin
      k = body.size() - nlen + $urandom_range(0, nlen - 1);
      body[k] ^= octet_t'($urandom_range(1, 255));
    end
    add_word(body);
    sz = body.size();
    // A declared size that is off in either direction breaks the section apart; now and then the body is dropped.
    case ($urandom_range(0, 19))
      0, 1: sz = $urandom_range(0, sz);
      2: sz = sz + $urandom_range(1, 3);
      3: begin
        body.delete();
        sz = 0;
      end
      default: ;
    endcase
    image.push_back(8'h00);
    add_leb(image, sz, pad_width());
    foreach (body[i]) image.push_back(body[i]);
  endfunction

  // Any other section id with a short random body. Now and then the size field is
  // malformed, or it announces a huge body that the module never delivers.
  function automatic void add_plain();
    int n;
    image.push_back(octet_t'($urandom_range(1, 255)));
    case ($urandom_range(0, 19))
      0: begin
        add_bad_leb(image);
        return;
      end
      1: begin
        add_leb(image, 32'h8000_0000 | $urandom(), 5);
        repeat ($urandom_range(0, 4)) image.push_back(octet_t'($urandom_range(0, 255)));
        return;
      end
      default: ;
    endcase
    n = $urandom_range(0, 8);
    add_leb(image, n, pad_width());
    repeat (n) image.push_back(octet_t'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed modules with random sections; a few are noise, carry a broken
  // header, or are cut off at a random byte.
  function automatic void build_module();
    int kind;
    int cut;
    image.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 10)) image.push_back(octet_t'($urandom_range(0, 255)));
      return;
    end
    for (int k = 0; k < 8; k++) image.push_back(wlsc_pkg::MAGIC[k]);
    if (kind < 10) image[$urandom_range(0, 7)] ^= octet_t'($urandom_range(1, 255));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) == 0) add_plain();
      else add_custom();
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, image.size() - 1);
      while (image.size() > cut) void'(image.pop_back());
    end
  endfunction

  initial begin
    bit [63:0] zero_words [4];
    int        guard;
    foreach (zero_words[i]) zero_words[i] = '0;
    bytes_sent = 0;
    modules_sent = 0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.end_of_module <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= wlsc_pkg::CFG_NAME_LENGTH;
    cfg_chan.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Start with an empty configured name so that a custom section with a zero-length
    // name is the language section.
    write_name_regs(6'd0, zero_words);

    // Directed modules: a lone all-ones byte is not a module at all, a bare header
    // declares nothing, and a header followed by an empty-named custom section
    // holding the word rust is a clean result.
    image.delete();
    image.push_back(8'hff);
    send_image();
    image.delete();
    for (int k = 0; k < 8; k++) image.push_back(wlsc_pkg::MAGIC[k]);
    send_image();
    image.delete();
    for (int k = 0; k < 8; k++) image.push_back(wlsc_pkg::MAGIC[k]);
    image.push_back(8'h00);
    image.push_back(8'h05);
    image.push_back(8'h00);
    for (int k = 0; k < wlsc_pkg::RUST_LEN; k++) image.push_back(wlsc_pkg::RUST_WORD[k]);
    send_image();

    // Random modules. The configured name only changes while the parser is idle.
    while (bytes_sent < BYTE_TARGET) begin
      if (modules_sent % 8 == 0) begin
        settle();
        pick_setting();
      end
      quiet = ($urandom_range(0, 4) == 0);
      build_module();
      send_image();
    end

    // Drain: every verdict must come back within a bounded number of cycles.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (sb.verdict_q.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (sb.verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.verdict_q.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wlsc_pkg.sv
hdl/wlsc_if.sv
hdl/wlsc_result_reg.sv
hdl/wasm_language_section_checker.sv
bench/testbench.sv
